FILE: rtl/sbhi_pkg.sv
`default_nettype none

package sbhi_pkg;

    typedef enum logic [2:0] {
        OP_ADD         = 3'd0,
        OP_QUERY       = 3'd1,
        OP_PLANE_COUNT = 3'd2,
        OP_TOTAL_COUNT = 3'd3,
        OP_CLEAR       = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_UNKNOWN_SRC  = 3'd1,
        ST_PLANE_FULL   = 3'd2,
        ST_SECTOR_RANGE = 3'd3,
        ST_BUCKET_FULL  = 3'd4,
        ST_NONE_FOUND   = 3'd5,
        ST_TRUNCATED    = 3'd6
    } status_t;

    localparam logic [2:0] REG_PITCH  = 3'd0;
    localparam logic [2:0] REG_PLANE0 = 3'd1;
    localparam int         PLANE_REGS = 6;

    localparam logic [22:0] PITCH_RESET = 23'd256;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 3;

endpackage

`default_nettype wire

FILE: rtl/sbhi_ram.sv
`default_nettype none

module sbhi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                       clk,
    input  wire [$clog2(DEPTH)-1:0]   addr,
    input  wire                       we,
    input  wire [WIDTH-1:0]           wdata,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/sector_binned_hit_index.sv
// channel  | dir | ports                          | content
// s_axis   | in  | tvalid tready tdata tuser      | one command beat
// m_axis   | out | tvalid tready tdata tlast      | result beats, tlast on final one
// cfg      | in  | cfg_we cfg_index cfg_data      | register write, no read-back
//
// Sector index comes from one restoring divider, one quotient bit a cycle.
// A query walks each bucket in its sector window and each id found; clear sweeps the fill memory.
// After reset the fill memory is swept before tready rises.
// One command at a time; a stalled result beat holds the sequencer where it stands.
`default_nettype none

module sector_binned_hit_index #(
    parameter int PLANES            = 6,
    parameter int HITS_PER_PLANE    = 256,
    parameter int SECTORS           = 64,
    parameter int BUCKET_DEPTH      = 16,
    parameter int MAX_QUERY_RESULTS = 64
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // source_id[7:0], plane[10:8], u_position[34:11], u_window[57:35], zero pad
    input  wire [sbhi_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode[2:0]
    input  wire [sbhi_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // status[2:0], hit_id[10:3], hit_count[21:11], zero pad
    output logic [sbhi_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    input  wire                                cfg_we,
    input  wire [sbhi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [sbhi_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import sbhi_pkg::*;

    localparam int PW = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int CW = $clog2(HITS_PER_PLANE + 1);
    localparam int SW = $clog2(SECTORS);
    localparam int NB = PLANES * SECTORS;
    localparam int BW = $clog2(NB);
    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int KW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int NE = NB * BUCKET_DEPTH;
    localparam int EW = $clog2(NE);
    localparam int NW = $clog2(MAX_QUERY_RESULTS + 1);
    localparam int DCW = 5;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_DIV, S_POST, S_ADD_RD, S_ADD_CHK, S_TOTAL,
        S_Q_FRD, S_Q_FCHK, S_Q_ERD, S_Q_ECHK, S_Q_DONE, S_RESULT
    } state_t;

    function automatic logic [23:0] mag24(input logic signed [24:0] a);
        logic signed [24:0] n;
        n = -a;
        return a[24] ? n[23:0] : a[23:0];
    endfunction

    state_t state_reg;

    logic [22:0]  pitch_reg;
    logic [7:0]   pid_reg [PLANE_REGS];
    logic [CW-1:0] cnt_reg [PLANES];

    op_t          op_reg;
    logic [7:0]   src_reg;
    logic [2:0]   pl_reg;
    logic signed [23:0] u_reg;
    logic [22:0]  win_reg;

    logic [23:0]  dvd_reg;
    logic [23:0]  rem_reg;
    logic         dneg_reg;
    logic [DCW-1:0] dcnt_reg;
    logic         qphase_reg;
    logic signed [25:0] lo_reg;

    logic [PW-1:0] psel_reg;
    logic [BW-1:0] bkt_reg;
    logic [BW-1:0] bkt_hi_reg;
    logic [BW-1:0] clr_reg;
    logic          clr_res_reg;
    logic [FW-1:0] fill_cnt_reg;
    logic [KW-1:0] k_reg;
    logic [NW-1:0] n_reg;
    logic          held_v_reg;
    logic [7:0]    held_reg;
    logic [PW-1:0] pidx_reg;
    logic [10:0]   acc_reg;

    status_t       res_status_reg;
    logic [7:0]    res_id_reg;
    logic [10:0]   res_cnt_reg;

    logic          m_valid_reg;
    status_t       m_status_reg;
    logic [7:0]    m_id_reg;
    logic [10:0]   m_cnt_reg;
    logic          m_last_reg;

    logic               out_free;
    logic               m_load;
    logic [22:0]        pitch_eff;
    logic               found_v;
    logic [PW-1:0]      found_idx;
    logic signed [24:0] u25;
    logic signed [24:0] d25;
    logic signed [24:0] u_minus_d;
    logic signed [24:0] u_plus_d;
    logic [23:0]        rem_sh;
    logic               div_ge;
    logic [23:0]        rem_next;
    logic [23:0]        dvd_next;
    logic signed [25:0] q26;
    logic signed [25:0] fl26;
    logic signed [25:0] slot26;
    logic               slot_ok;
    logic signed [25:0] lo_c;
    logic signed [25:0] hi_c;
    logic               q_empty;
    logic [BW-1:0]      add_bkt;
    logic [BW-1:0]      q_lo_bkt;
    logic [BW-1:0]      q_hi_bkt;
    logic [FW-1:0]      kidx;
    logic [FW-1:0]      k_plus1;
    logic [CW-1:0]      pcount;
    logic               add_ok;

    logic [BW-1:0]      fill_addr;
    logic               fill_we;
    logic [FW-1:0]      fill_wdata;
    logic [FW-1:0]      fill_rdata;
    logic [EW-1:0]      ent_addr;
    logic               ent_we;
    logic [7:0]         ent_rdata;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign m_load    = out_free &&
                       ((state_reg == S_RESULT) ||
                        ((state_reg == S_Q_DONE) && held_v_reg) ||
                        ((state_reg == S_Q_ECHK) && held_v_reg));
    assign pitch_eff = (pitch_reg == 23'd0) ? 23'd1 : pitch_reg;

    always_comb
    begin
        found_v   = 1'b0;
        found_idx = '0;
        for (int i = PLANES - 1; i >= 0; i--)
        begin
            if (pid_reg[i] == src_reg)
            begin
                found_v   = 1'b1;
                found_idx = PW'(i);
            end
        end
    end

    assign u25       = 25'(u_reg);
    assign d25       = $signed({2'b00, win_reg});
    assign u_minus_d = u25 - d25;
    assign u_plus_d  = u25 + d25;

    assign rem_sh   = {rem_reg[22:0], dvd_reg[23]};
    assign div_ge   = rem_sh >= {1'b0, pitch_eff};
    assign rem_next = div_ge ? (rem_sh - {1'b0, pitch_eff}) : rem_sh;
    assign dvd_next = {dvd_reg[22:0], div_ge};

    assign q26    = $signed({2'b00, dvd_reg});
    assign fl26   = dneg_reg ? (-q26 - $signed({25'd0, |rem_reg})) : q26;
    assign slot26 = fl26 + $signed(26'(SECTORS / 2));
    assign slot_ok = !slot26[25] && (slot26 < $signed(26'(SECTORS)));

    assign lo_c    = lo_reg[25] ? 26'sd0 : lo_reg;
    assign hi_c    = (slot26 > $signed(26'(SECTORS - 1))) ? $signed(26'(SECTORS - 1)) : slot26;
    assign q_empty = lo_c > hi_c;

    assign add_bkt  = BW'(psel_reg) * BW'(SECTORS) + BW'(slot26[SW-1:0]);
    assign q_lo_bkt = BW'(psel_reg) * BW'(SECTORS) + BW'(lo_c[SW-1:0]);
    assign q_hi_bkt = BW'(psel_reg) * BW'(SECTORS) + BW'(hi_c[SW-1:0]);

    assign pcount  = (pl_reg < 3'(PLANES)) ? cnt_reg[pl_reg[PW-1:0]] : '0;
    assign add_ok  = fill_rdata < FW'(BUCKET_DEPTH);
    assign kidx    = (state_reg == S_ADD_CHK) ? fill_rdata : FW'(k_reg);
    assign k_plus1 = FW'(k_reg) + FW'(1);

    assign fill_addr  = (state_reg == S_CLEAR) ? clr_reg : bkt_reg;
    assign fill_we    = (state_reg == S_CLEAR) || ((state_reg == S_ADD_CHK) && add_ok);
    assign fill_wdata = (state_reg == S_CLEAR) ? '0 : (fill_rdata + FW'(1));
    assign ent_addr   = EW'(bkt_reg) * EW'(BUCKET_DEPTH) + EW'(kidx);
    assign ent_we     = (state_reg == S_ADD_CHK) && add_ok;

    sbhi_ram #(
        .WIDTH (FW),
        .DEPTH (NB)
    ) u_fill_ram (
        .clk   (clk),
        .addr  (fill_addr),
        .we    (fill_we),
        .wdata (fill_wdata),
        .rdata (fill_rdata)
    );

    sbhi_ram #(
        .WIDTH (8),
        .DEPTH (NE)
    ) u_entry_ram (
        .clk   (clk),
        .addr  (ent_addr),
        .we    (ent_we),
        .wdata (8'(cnt_reg[psel_reg])),
        .rdata (ent_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            pitch_reg      <= PITCH_RESET;
            for (int i = 0; i < PLANE_REGS; i++)
            begin
                pid_reg[i] <= 8'(i);
            end
            for (int i = 0; i < PLANES; i++)
            begin
                cnt_reg[i] <= '0;
            end
            op_reg         <= OP_ADD;
            src_reg        <= '0;
            pl_reg         <= '0;
            u_reg          <= '0;
            win_reg        <= '0;
            dvd_reg        <= '0;
            rem_reg        <= '0;
            dneg_reg       <= 1'b0;
            dcnt_reg       <= '0;
            qphase_reg     <= 1'b0;
            lo_reg         <= '0;
            psel_reg       <= '0;
            bkt_reg        <= '0;
            bkt_hi_reg     <= '0;
            clr_reg        <= '0;
            clr_res_reg    <= 1'b0;
            fill_cnt_reg   <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
            held_v_reg     <= 1'b0;
            held_reg       <= '0;
            pidx_reg       <= '0;
            acc_reg        <= '0;
            res_status_reg <= ST_OK;
            res_id_reg     <= '0;
            res_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
            m_status_reg   <= ST_OK;
            m_id_reg       <= '0;
            m_cnt_reg      <= '0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PITCH)
                begin
                    pitch_reg <= cfg_data;
                end
                else if (cfg_index >= REG_PLANE0 &&
                         cfg_index <= REG_PLANE0 + 3'(PLANE_REGS - 1))
                begin
                    pid_reg[cfg_index - REG_PLANE0] <= cfg_data[7:0];
                end
            end

            if (m_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_reg == BW'(NB - 1))
                    begin
                        clr_reg        <= '0;
                        res_status_reg <= ST_OK;
                        res_id_reg     <= '0;
                        res_cnt_reg    <= '0;
                        state_reg      <= clr_res_reg ? S_RESULT : S_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + BW'(1);
                    end
                end

                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg    <= op_t'(s_axis_tuser);
                        src_reg   <= s_axis_tdata[7:0];
                        pl_reg    <= s_axis_tdata[10:8];
                        u_reg     <= s_axis_tdata[34:11];
                        win_reg   <= s_axis_tdata[57:35];
                        state_reg <= S_DISPATCH;
                    end
                end

                S_DISPATCH:
                begin
                    res_id_reg  <= '0;
                    res_cnt_reg <= (op_reg == OP_PLANE_COUNT) ? 11'(pcount) : 11'd0;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (!found_v)
                            begin
                                res_status_reg <= ST_UNKNOWN_SRC;
                                state_reg      <= S_RESULT;
                            end
                            else if (cnt_reg[found_idx] >= CW'(HITS_PER_PLANE))
                            begin
                                res_status_reg <= ST_PLANE_FULL;
                                state_reg      <= S_RESULT;
                            end
                            else
                            begin
                                psel_reg  <= found_idx;
                                dvd_reg   <= mag24(u25);
                                dneg_reg  <= u25[24];
                                rem_reg   <= '0;
                                dcnt_reg  <= DCW'(24);
                                state_reg <= S_DIV;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (pl_reg >= 3'(PLANES))
                            begin
                                res_status_reg <= ST_NONE_FOUND;
                                state_reg      <= S_RESULT;
                            end
                            else
                            begin
                                psel_reg   <= pl_reg[PW-1:0];
                                qphase_reg <= 1'b0;
                                dvd_reg    <= mag24(u_minus_d);
                                dneg_reg   <= u_minus_d[24];
                                rem_reg    <= '0;
                                dcnt_reg   <= DCW'(24);
                                state_reg  <= S_DIV;
                            end
                        end
                        OP_PLANE_COUNT:
                        begin
                            res_status_reg <= ST_OK;
                            state_reg      <= S_RESULT;
                        end
                        OP_TOTAL_COUNT:
                        begin
                            acc_reg   <= '0;
                            pidx_reg  <= '0;
                            state_reg <= S_TOTAL;
                        end
                        OP_CLEAR:
                        begin
                            for (int i = 0; i < PLANES; i++)
                            begin
                                cnt_reg[i] <= '0;
                            end
                            clr_reg     <= '0;
                            clr_res_reg <= 1'b1;
                            state_reg   <= S_CLEAR;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_DIV:
                begin
                    rem_reg  <= rem_next;
                    dvd_reg  <= dvd_next;
                    dcnt_reg <= dcnt_reg - DCW'(1);
                    if (dcnt_reg == DCW'(1))
                    begin
                        state_reg <= S_POST;
                    end
                end

                S_POST:
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (!slot_ok)
                        begin
                            res_status_reg <= ST_SECTOR_RANGE;
                            state_reg      <= S_RESULT;
                        end
                        else
                        begin
                            bkt_reg   <= add_bkt;
                            state_reg <= S_ADD_RD;
                        end
                    end
                    else if (!qphase_reg)
                    begin
                        lo_reg     <= slot26;
                        qphase_reg <= 1'b1;
                        dvd_reg    <= mag24(u_plus_d);
                        dneg_reg   <= u_plus_d[24];
                        rem_reg    <= '0;
                        dcnt_reg   <= DCW'(24);
                        state_reg  <= S_DIV;
                    end
                    else if (q_empty)
                    begin
                        res_status_reg <= ST_NONE_FOUND;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        bkt_reg    <= q_lo_bkt;
                        bkt_hi_reg <= q_hi_bkt;
                        n_reg      <= '0;
                        held_v_reg <= 1'b0;
                        state_reg  <= S_Q_FRD;
                    end
                end

                S_ADD_RD:
                begin
                    state_reg <= S_ADD_CHK;
                end

                S_ADD_CHK:
                begin
                    if (!add_ok)
                    begin
                        res_status_reg <= ST_BUCKET_FULL;
                    end
                    else
                    begin
                        res_status_reg    <= ST_OK;
                        res_id_reg        <= 8'(cnt_reg[psel_reg]);
                        cnt_reg[psel_reg] <= cnt_reg[psel_reg] + CW'(1);
                    end
                    state_reg <= S_RESULT;
                end

                S_TOTAL:
                begin
                    acc_reg  <= acc_reg + 11'(cnt_reg[pidx_reg]);
                    pidx_reg <= pidx_reg + PW'(1);
                    if (pidx_reg == PW'(PLANES - 1))
                    begin
                        res_status_reg <= ST_OK;
                        res_cnt_reg    <= acc_reg + 11'(cnt_reg[pidx_reg]);
                        state_reg      <= S_RESULT;
                    end
                end

                S_Q_FRD:
                begin
                    state_reg <= S_Q_FCHK;
                end

                S_Q_FCHK:
                begin
                    if (fill_rdata != '0)
                    begin
                        fill_cnt_reg <= fill_rdata;
                        k_reg        <= '0;
                        state_reg    <= S_Q_ERD;
                    end
                    else if (bkt_reg == bkt_hi_reg)
                    begin
                        state_reg <= S_Q_DONE;
                    end
                    else
                    begin
                        bkt_reg   <= bkt_reg + BW'(1);
                        state_reg <= S_Q_FRD;
                    end
                end

                S_Q_ERD:
                begin
                    state_reg <= S_Q_ECHK;
                end

                S_Q_ECHK:
                begin
                    if (n_reg == NW'(MAX_QUERY_RESULTS))
                    begin
                        if (out_free)
                        begin
                            m_status_reg <= ST_TRUNCATED;
                            m_id_reg     <= held_reg;
                            m_cnt_reg    <= '0;
                            m_last_reg   <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                    end
                    else if (!held_v_reg || out_free)
                    begin
                        if (held_v_reg)
                        begin
                            m_status_reg <= ST_OK;
                            m_id_reg     <= held_reg;
                            m_cnt_reg    <= '0;
                            m_last_reg   <= 1'b0;
                        end
                        held_reg   <= ent_rdata;
                        held_v_reg <= 1'b1;
                        n_reg      <= n_reg + NW'(1);
                        if (k_plus1 < fill_cnt_reg)
                        begin
                            k_reg     <= k_reg + KW'(1);
                            state_reg <= S_Q_ERD;
                        end
                        else if (bkt_reg == bkt_hi_reg)
                        begin
                            state_reg <= S_Q_DONE;
                        end
                        else
                        begin
                            bkt_reg   <= bkt_reg + BW'(1);
                            state_reg <= S_Q_FRD;
                        end
                    end
                end

                S_Q_DONE:
                begin
                    if (held_v_reg)
                    begin
                        if (out_free)
                        begin
                            m_status_reg <= ST_OK;
                            m_id_reg     <= held_reg;
                            m_cnt_reg    <= '0;
                            m_last_reg   <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                    end
                    else
                    begin
                        res_status_reg <= ST_NONE_FOUND;
                        res_id_reg     <= '0;
                        res_cnt_reg    <= '0;
                        state_reg      <= S_RESULT;
                    end
                end

                S_RESULT:
                begin
                    if (out_free)
                    begin
                        m_status_reg <= res_status_reg;
                        m_id_reg     <= res_id_reg;
                        m_cnt_reg    <= res_cnt_reg;
                        m_last_reg   <= 1'b1;
                        clr_res_reg  <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_cnt_reg, m_id_reg, m_status_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

FILE: rtl/sbhi_checker.sv
`default_nettype none

module sbhi_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire [sbhi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire                              m_axis_tlast
);

    import sbhi_pkg::*;

    logic [2:0]  status;
    logic [7:0]  hit_id;
    logic [10:0] hit_count;

    assign status    = m_axis_tdata[2:0];
    assign hit_id    = m_axis_tdata[10:3];
    assign hit_count = m_axis_tdata[21:11];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command taken while previous one in progress");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status != ST_OK |-> m_axis_tlast)
        else $error("non-ok status on a beat that is not final");

    a_count_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && hit_count != 11'd0 |->
            hit_id == 8'd0 && status == ST_OK && m_axis_tlast)
        else $error("count beat carries an id or bad status");

endmodule

bind sector_binned_hit_index sbhi_checker u_sbhi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: sim/sector_binned_hit_index_tb.sv
`default_nettype none

class sbhi_scoreboard;
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  hit_id;
        logic [10:0] hit_count;
        logic        last;
    } hit_result_t;

    logic [22:0]  pitch;
    logic [7:0]   plane_src [6];
    int unsigned  plane_hits [6];
    int unsigned  fill [6*64];
    logic [7:0]   entries [6*64*16];
    hit_result_t  pending [$];
    int           errors;

    function new();
        errors = 0;
        pitch = 23'd256;
        for (int i = 0; i < 6; i++)
        begin
            plane_src[i] = 8'(i);
        end
        wipe();
    endfunction

    function void wipe();
        for (int i = 0; i < 6; i++)
        begin
            plane_hits[i] = 0;
        end
        for (int i = 0; i < 6*64; i++)
        begin
            fill[i] = 0;
        end
    endfunction

    function void write_reg(int idx, logic [22:0] val);
        if (idx == 0)
        begin
            pitch = val;
        end
        else if (idx <= 6)
        begin
            plane_src[idx-1] = val[7:0];
        end
    endfunction

    function longint fdiv(longint a, longint p);
        longint q;
        q = a / p;
        if ((a % p) != 0 && a < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function void push(logic [2:0] st, logic [7:0] id, logic [10:0] cnt, logic lst);
        hit_result_t r;
        r.status = st;
        r.hit_id = id;
        r.hit_count = cnt;
        r.last = lst;
        pending.insert(pending.size(), r);
    endfunction

    function void note_command(logic [2:0] op, logic [7:0] src, logic [2:0] pl,
                               logic signed [23:0] u, logic [22:0] d);
        longint p;
        longint slot;
        longint lo;
        longint hi;
        int found;
        int b;
        int n;
        int unsigned t;
        bit trunc;
        p = (pitch == 0) ? 1 : longint'(pitch);
        case (op)
            sbhi_pkg::OP_ADD:
            begin
                found = -1;
                for (int i = 0; i < 6; i++)
                begin
                    if (found < 0 && plane_src[i] == src)
                    begin
                        found = i;
                    end
                end
                slot = fdiv(longint'(u), p) + 32;
                if (found < 0)
                begin
                    push(sbhi_pkg::ST_UNKNOWN_SRC, 0, 0, 1);
                end
                else if (plane_hits[found] >= 256)
                begin
                    push(sbhi_pkg::ST_PLANE_FULL, 0, 0, 1);
                end
                else if (slot < 0 || slot >= 64)
                begin
                    push(sbhi_pkg::ST_SECTOR_RANGE, 0, 0, 1);
                end
                else
                begin
                    b = found * 64 + int'(slot);
                    if (fill[b] >= 16)
                    begin
                        push(sbhi_pkg::ST_BUCKET_FULL, 0, 0, 1);
                    end
                    else
                    begin
                        entries[b*16 + fill[b]] = 8'(plane_hits[found]);
                        fill[b]++;
                        push(sbhi_pkg::ST_OK, 8'(plane_hits[found]), 0, 1);
                        plane_hits[found]++;
                    end
                end
            end
            sbhi_pkg::OP_QUERY:
            begin
                n = 0;
                trunc = 0;
                if (pl >= 6)
                begin
                    push(sbhi_pkg::ST_NONE_FOUND, 0, 0, 1);
                end
                else
                begin
                    lo = fdiv(longint'(u) - longint'(d), p) + 32;
                    hi = fdiv(longint'(u) + longint'(d), p) + 32;
                    if (lo < 0) lo = 0;
                    if (hi > 63) hi = 63;
                    for (longint s = lo; s <= hi && !trunc; s++)
                    begin
                        b = int'(pl) * 64 + int'(s);
                        for (int k = 0; k < fill[b] && !trunc; k++)
                        begin
                            if (n >= 64)
                            begin
                                trunc = 1;
                            end
                            else
                            begin
                                push(sbhi_pkg::ST_OK, entries[b*16 + k], 0, 0);
                                n++;
                            end
                        end
                    end
                    if (n == 0)
                    begin
                        push(sbhi_pkg::ST_NONE_FOUND, 0, 0, 1);
                    end
                    else
                    begin
                        pending[$].last = 1;
                        if (trunc)
                        begin
                            pending[$].status = sbhi_pkg::ST_TRUNCATED;
                        end
                    end
                end
            end
            sbhi_pkg::OP_PLANE_COUNT:
            begin
                push(sbhi_pkg::ST_OK, 0, (pl < 6) ? 11'(plane_hits[pl]) : 11'd0, 1);
            end
            sbhi_pkg::OP_TOTAL_COUNT:
            begin
                t = 0;
                for (int i = 0; i < 6; i++)
                begin
                    t += plane_hits[i];
                end
                push(sbhi_pkg::ST_OK, 0, 11'(t), 1);
            end
            sbhi_pkg::OP_CLEAR:
            begin
                wipe();
                push(sbhi_pkg::ST_OK, 0, 0, 1);
            end
            default:
            begin
            end
        endcase
    endfunction

    task report(string what, logic [10:0] got, logic [10:0] want);
        $display("beat error: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check_beat(logic [23:0] data, logic lst);
        hit_result_t w;
        if (pending.size() == 0)
        begin
            report("unexpected beat", 11'(data[2:0]), 0);
            return;
        end
        w = pending.pop_front();
        if (data[2:0] != w.status) report("status", 11'(data[2:0]), 11'(w.status));
        if (data[10:3] != w.hit_id) report("hit_id", 11'(data[10:3]), 11'(w.hit_id));
        if (data[21:11] != w.hit_count) report("hit_count", data[21:11], w.hit_count);
        if (lst != w.last) report("last", 11'(lst), 11'(w.last));
    endtask
endclass

module sector_binned_hit_index_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    wire         s_axis_tready;
    logic [63:0] s_axis_tdata = 0;
    logic [2:0]  s_axis_tuser = 0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 0;
    wire  [23:0] m_axis_tdata;
    wire         m_axis_tlast;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = 0;
    logic [22:0] cfg_data = 0;

    sbhi_scoreboard sb;
    int          idle_pct = 38;
    bit          hold_off = 0;
    longint      cycles = 0;

    sector_binned_hit_index dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("sector_binned_hit_index: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            sb.check_beat(m_axis_tdata, m_axis_tlast);
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= !hold_off && ($urandom_range(99) >= idle_pct);
    end

    task send(logic [2:0] op, logic [7:0] src, logic [2:0] pl,
              logic [23:0] u, logic [22:0] d);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
        end
        s_axis_tvalid = 1;
        s_axis_tuser = op;
        s_axis_tdata = {6'd0, d, u, pl, src};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_command(op, src, pl, u, d);
        @(negedge clk);
        s_axis_tvalid = 0;
    endtask

    task drain();
        while (sb.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (500) @(negedge clk);
    endtask

    task write_reg(int idx, logic [22:0] val);
        cfg_we = 1;
        cfg_index = 3'(idx);
        cfg_data = val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task random_cmd(int pitch_hint);
        int r;
        logic [23:0] u;
        r = $urandom_range(99);
        if ($urandom_range(9) == 0)
        begin
            u = $urandom;
        end
        else
        begin
            u = 24'($signed($urandom_range(64 * pitch_hint)) - 32 * pitch_hint);
        end
        if (r < 55)
            send(sbhi_pkg::OP_ADD, ($urandom_range(9) == 0) ? 8'($urandom) :
                 8'($urandom_range(5)), 0, u, 0);
        else if (r < 80)
            send(sbhi_pkg::OP_QUERY, 8'($urandom), 3'($urandom_range(6)), u,
                 ($urandom_range(4) == 0) ? 23'($urandom) : 23'($urandom_range(3*pitch_hint)));
        else if (r < 88)
            send(sbhi_pkg::OP_PLANE_COUNT, 8'($urandom), 3'($urandom), u, 23'($urandom));
        else if (r < 93)
            send(sbhi_pkg::OP_TOTAL_COUNT, 8'($urandom), 3'($urandom), u, 23'($urandom));
        else if (r < 96)
            send(sbhi_pkg::OP_CLEAR, 0, 0, 0, 0);
        else
            send(3'($urandom_range(7, 5)), 8'($urandom), 3'($urandom), u, 23'($urandom));
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(negedge clk);
        rst_n <= 1;
        send(sbhi_pkg::OP_ADD, 0, 0, 24'h7FFFFF, 0);
        send(sbhi_pkg::OP_ADD, 1, 0, 24'h800000, 0);
        send(sbhi_pkg::OP_ADD, 2, 0, 24'hFFFF00, 0);
        send(sbhi_pkg::OP_ADD, 9, 0, 0, 0);
        send(sbhi_pkg::OP_ADD, 8'hFF, 7, 24'hFFFFFF, 23'h7FFFFF);
        for (int i = 0; i < 17; i++)
            send(sbhi_pkg::OP_ADD, 3, 0, 24'(i), 0);
        send(sbhi_pkg::OP_QUERY, 0, 3, 0, 23'h7FFFFF);
        send(sbhi_pkg::OP_QUERY, 0, 4, 0, 0);
        send(sbhi_pkg::OP_QUERY, 0, 6, 0, 0);
        send(sbhi_pkg::OP_PLANE_COUNT, 0, 3, 0, 0);
        send(sbhi_pkg::OP_PLANE_COUNT, 0, 7, 0, 0);
        send(sbhi_pkg::OP_TOTAL_COUNT, 0, 0, 0, 0);
        send(3'd7, 0, 0, 0, 0);
        send(sbhi_pkg::OP_CLEAR, 0, 0, 0, 0);
        drain();
        write_reg(0, 0);
        write_reg(1, 8'hFF);
        write_reg(2, 8'hFF);
        write_reg(3, 8'h80);
        write_reg(4, 8'h7F);
        write_reg(5, 8'h55);
        write_reg(6, 8'hAA);
        for (int i = 0; i < 70; i++)
            send(sbhi_pkg::OP_ADD, 8'hFF, 0, 24'($urandom_range(31)), 0);
        send(sbhi_pkg::OP_QUERY, 0, 0, 24'd15, 23'd40);
        drain();
        hold_off = 1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++)
                send(sbhi_pkg::OP_PLANE_COUNT, 0, 3'(i), 0, 0);
        join
        drain();
        for (int i = 1; i <= 6; i++)
            write_reg(i, 23'(i - 1));
        for (int ph = 0; ph < 4; ph++)
        begin
            int ph_pitch;
            ph_pitch = (ph == 0) ? 8 : (ph == 1) ? 256 : (ph == 2) ? 1 : 8388607;
            write_reg(0, 23'(ph_pitch));
            idle_pct = (ph == 1) ? 0 : 38;
            for (int i = 0; i < 27; i++)
                random_cmd((ph_pitch > 100000) ? 100000 : ph_pitch);
            drain();
            send(sbhi_pkg::OP_TOTAL_COUNT, 0, 0, 0, 0);
            drain();
        end
        write_reg(3, 8'd2);
        for (int i = 0; i < 10; i++)
            random_cmd(8);
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("sector_binned_hit_index: match");
        end
        else
        begin
            $display("sector_binned_hit_index: mismatch");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: sim.f
rtl/sbhi_pkg.sv
rtl/sbhi_ram.sv
rtl/sector_binned_hit_index.sv
rtl/sbhi_checker.sv
sim/sector_binned_hit_index_tb.sv
